// File: src/escape_rle_stream_decoder_assert.svh
// Assertion macros for the escape RLE stream decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ESCAPE_RLE_STREAM_DECODER_ASSERT_SVH
`define ESCAPE_RLE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ERLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erle check failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ERLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erle check failed: next-cycle implication");

`endif

// File: src/erle_pkg.sv
// Shared types and constants for the escape RLE stream decoder.
// Used by every module of the block; depends on nothing.
package erle_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 24;
   localparam int REPEAT_W = 9;
   localparam int STATUS_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int RSP_DATA_W = 24;

   // Register index, taken from paddr[2]
   localparam logic CSR_IDX_EXPECTED_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      PH_HDR0      = 3'd0,
      PH_HDR1      = 3'd1,
      PH_HDR2      = 3'd2,
      PH_ESCDEF    = 3'd3,
      PH_BODY      = 3'd4,
      PH_AFTER_ESC = 3'd5,
      PH_AFTER_CNT = 3'd6,
      PH_DISCARD   = 3'd7
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_TRUNC    = 3'd3,
      ST_SHORT    = 3'd4,
      ST_BUSY     = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [REPEAT_W-1:0] repeat_count;
      status_type          status;
      logic                done_res;
   } rsp_item_type;

endpackage

// File: src/erle_csr.sv
// APB-style configuration register holding expected_length.
// Depends on erle_pkg for widths and the register index.
module erle_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [erle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [erle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [erle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [erle_pkg::LEN_W-1:0]        expected_length
);
   import erle_pkg::*;

   logic [LEN_W-1:0] expected_ff;
   logic [LEN_W-1:0] expected_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready
                  & (csr_paddr[2] == CSR_IDX_EXPECTED_LENGTH);

   always_comb begin
      expected_in = expected_ff;
      if (wr_en) begin
         expected_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else begin
         expected_ff <= expected_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_EXPECTED_LENGTH) begin
         csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, expected_ff};
      end
   end

   assign expected_length = expected_ff;

endmodule

// File: src/erle_in_stage.sv
// Input register for packed record bytes, one request per cycle while the held one is popped.
// Depends on erle_pkg for the request item type.
module erle_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  erle_pkg::req_item_type req_item,
   input  logic                   pop,
   output logic                   item_valid,
   output erle_pkg::req_item_type item
);
   import erle_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // Take a new request when empty or when the held one moves on this cycle
   assign req_ready = ~valid_ff | pop;
   assign load      = req_valid & req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: src/erle_core.sv
// Record phase machine, run-length decode and result register.
// Depends on erle_pkg and the assertion macro header.
`include "escape_rle_stream_decoder_assert.svh"

module erle_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [erle_pkg::LEN_W-1:0]    expected_length,
   input  logic                          item_valid,
   input  erle_pkg::req_item_type        item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output erle_pkg::rsp_item_type        rsp_item
);
   import erle_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [15:0]      decl_hi_ff, decl_hi_in;   // first two header bytes
   logic [BYTE_W-1:0] esc_ff, esc_in;
   logic [BYTE_W-1:0] pend_ff, pend_in;
   logic [LEN_W-1:0] produced_ff, produced_in;
   logic             out_valid_ff, out_valid_in;
   rsp_item_type     out_ff;

   logic [BYTE_W-1:0]   b;
   logic                last;
   logic                emit_req;
   logic [BYTE_W-1:0]   emit_value;
   logic [REPEAT_W-1:0] emit_count;
   logic [LEN_W:0]      sum;
   logic                overflow;
   logic                mismatch;
   logic                res_valid;
   rsp_item_type        res;

   assign b    = item.in_byte;
   assign last = item.in_last;

   // Move the held byte on when the result register is free or being drained
   assign pop = item_valid & (~out_valid_ff | rsp_ready);

   // Candidate data result and its overflow check
   always_comb begin
      emit_req   = 1'b0;
      emit_value = b;
      emit_count = REPEAT_W'(1);
      case (phase_ff)
         PH_BODY: begin
            emit_req = (b != esc_ff);
         end
         PH_AFTER_ESC: begin
            emit_req   = (b == '0);
            emit_value = esc_ff;
         end
         PH_AFTER_CNT: begin
            emit_req   = 1'b1;
            emit_count = {1'b0, pend_ff} + REPEAT_W'(1);
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   assign sum      = {1'b0, produced_ff} + {{(LEN_W+1-REPEAT_W){1'b0}}, emit_count};
   assign overflow = sum > {1'b0, expected_length};
   assign mismatch = {decl_hi_ff, b} != expected_length;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HDR0:   phase_in = last ? PH_HDR0 : PH_HDR1;
         PH_HDR1:   phase_in = last ? PH_HDR0 : PH_HDR2;
         PH_HDR2: begin
            if (last) begin
               phase_in = PH_HDR0;
            end else if (mismatch) begin
               phase_in = PH_DISCARD;
            end else begin
               phase_in = PH_ESCDEF;
            end
         end
         PH_ESCDEF: phase_in = last ? PH_HDR0 : PH_BODY;
         PH_BODY, PH_AFTER_ESC, PH_AFTER_CNT: begin
            if (last) begin
               phase_in = PH_HDR0;
            end else if (emit_req) begin
               phase_in = overflow ? PH_DISCARD : PH_BODY;
            end else if (phase_ff == PH_BODY) begin
               phase_in = PH_AFTER_ESC;
            end else begin
               phase_in = PH_AFTER_CNT;
            end
         end
         PH_DISCARD: phase_in = last ? PH_HDR0 : PH_DISCARD;
         default:   phase_in = PH_HDR0;
      endcase
   end

   // Record datapath registers
   always_comb begin
      decl_hi_in = decl_hi_ff;
      esc_in     = esc_ff;
      pend_in    = pend_ff;
      case (phase_ff)
         PH_HDR0:      decl_hi_in = {b, 8'h00};
         PH_HDR1:      decl_hi_in = {decl_hi_ff[15:8], b};
         PH_ESCDEF:    esc_in     = b;
         PH_AFTER_ESC: pend_in    = b;
         default:      pend_in    = pend_ff;
      endcase
      if (phase_in == PH_HDR0) begin
         produced_in = '0;
      end else if (emit_req && !overflow) begin
         produced_in = sum[LEN_W-1:0];
      end else begin
         produced_in = produced_ff;
      end
   end

   // Result for this byte
   always_comb begin
      res_valid        = 1'b0;
      res.out_byte     = '0;
      res.repeat_count = '0;
      res.status       = ST_TRUNC;
      res.done_res     = 1'b1;
      case (phase_ff)
         PH_HDR0, PH_HDR1: begin
            res_valid = last;
         end
         PH_HDR2: begin
            res_valid  = last | mismatch;
            res.status = last ? ST_TRUNC : ST_MISMATCH;
         end
         PH_ESCDEF: begin
            res_valid  = last;
            res.status = (expected_length == '0) ? ST_OK : ST_SHORT;
         end
         PH_BODY, PH_AFTER_ESC, PH_AFTER_CNT: begin
            if (emit_req) begin
               res_valid = 1'b1;
               if (overflow) begin
                  res.status = ST_OVERFLOW;
               end else begin
                  res.out_byte     = emit_value;
                  res.repeat_count = emit_count;
                  res.done_res     = last;
                  if (!last) begin
                     res.status = ST_BUSY;
                  end else if (sum[LEN_W-1:0] == expected_length) begin
                     res.status = ST_OK;
                  end else begin
                     res.status = ST_SHORT;
                  end
               end
            end else begin
               res_valid = last;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      if (pop) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         produced_ff  <= '0;
         decl_hi_ff   <= '0;
         esc_ff       <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            produced_ff <= produced_in;
            decl_hi_ff  <= decl_hi_in;
            esc_ff      <= esc_in;
            pend_ff     <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   `ERLE_ASSERT_NEXT(a_last_restarts, clock, reset, pop && item.in_last, phase_ff == PH_HDR0)
   `ERLE_ASSERT_IMPLY(a_busy_is_data, clock, reset, out_valid_ff && !out_ff.done_res,
      out_ff.status == ST_BUSY && out_ff.repeat_count != '0)
   `ERLE_ASSERT_IMPLY(a_status_only, clock, reset, out_valid_ff && out_ff.repeat_count == '0,
      out_ff.done_res && out_ff.out_byte == '0)

endmodule

// File: src/escape_rle_stream_decoder.sv
// An accepted request is registered in the input stage, and its result in the result register that drives rsp.
// Throughput: one packed byte per cycle while rsp is not stalled; header, escape and count bytes give no data result.
// A run is one result with its repeat count; the rate is set by the single-pass decode stage.
// Reset (synchronous, active high) clears the record phase, counters, both stages and
// expected_length (to 0); no clearing pass is needed.
module escape_rle_stream_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              req_tlast,   // in_last
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [erle_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [7:0] out_byte, [16:8] repeat_count
   output logic [erle_pkg::STATUS_W-1:0]     rsp_tuser,   // [2:0] status
   output logic                              rsp_tlast,   // done_res
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [erle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [erle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [erle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import erle_pkg::*;

   logic [LEN_W-1:0] expected_length;
   req_item_type     req_item;
   req_item_type     item;
   logic             item_valid;
   logic             pop;
   rsp_item_type     rsp_item;

   assign req_item.in_byte = req_tdata;
   assign req_item.in_last = req_tlast;

   erle_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .expected_length (expected_length)
   );

   erle_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   erle_core u_core (
      .clock           (clock),
      .reset           (reset),
      .expected_length (expected_length),
      .item_valid      (item_valid),
      .item            (item),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_item        (rsp_item)
   );

   assign rsp_tdata = {{(RSP_DATA_W-REPEAT_W-BYTE_W){1'b0}},
                       rsp_item.repeat_count, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.status;
   assign rsp_tlast = rsp_item.done_res;

endmodule
